### design/nmea_gga_pkg.sv
// ----------------------------------------------------------------------------
// nmea_gga_pkg
// Character codes, header tables and fixed-point constants for the GGA parser.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [2:0] HDR_FIRST = 3'd1;
  localparam logic [2:0] HDR_END   = 3'd6;

  localparam logic [3:0] FLD_UTC      = 4'd1;
  localparam logic [3:0] FLD_LAT      = 4'd2;
  localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
  localparam logic [3:0] FLD_LON      = 4'd4;
  localparam logic [3:0] FLD_LON_HEMI = 4'd5;
  localparam logic [3:0] FLD_ALT      = 4'd9;
  localparam logic [3:0] COMMA_MAX    = 4'd15;

  localparam logic [1:0] HEX_DONE = 2'd2;

  localparam logic [19:0] UTC_CAP       = 20'd999999;
  localparam logic [13:0] LAT_WHOLE_CAP = 14'd9999;
  localparam logic [16:0] LON_WHOLE_CAP = 17'd99999;
  localparam logic [20:0] ALT_CAP       = 21'd1000000;
  localparam logic [26:0] LAT_LIMIT     = 27'd90000000;
  localparam logic [29:0] LON_LIMIT     = 30'd180000000;

  // floor(x/100) = (x*M) >> S, exact over the full input width
  localparam logic [20:0] DIV100_M20 = 21'd1342178;
  localparam int          DIV100_S20 = 27;
  localparam logic [14:0] DIV100_M14 = 15'd20972;
  localparam int          DIV100_S14 = 21;
  localparam logic [17:0] DIV100_M17 = 18'd167773;
  localparam int          DIV100_S17 = 24;
  // floor(x/15) for x below 2^25
  localparam logic [25:0] DIV15_M25  = 26'd35791395;
  localparam int          DIV15_S25  = 29;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] gga_char(input logic [2:0] k);
    logic [7:0] ch;
    unique case (k)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h47;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [2:0] k);
    logic [7:0] ch;
    unique case (k)
      3'd0:    ch = 8'h43;
      3'd1:    ch = 8'h4D;
      3'd2:    ch = 8'h44;
      3'd3:    ch = 8'h49;
      3'd4:    ch = 8'h4E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [19:0] pow10(input logic [2:0] e);
    logic [19:0] p;
    unique case (e)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

### design/nmea_gga_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Byte-wise GGA sentence parser with checksum check and fixed-point position.
// ----------------------------------------------------------------------------
// one byte beat accepted per cycle while in_ready_o is high; bytes other than CR update state in place
// a CR beat inside a sentence is snapshotted, then passes through a 5-stage conversion pipe
// (divide by 100, remainders, micro scaling, divide by 60, saturate and sign)
// the pipe collapses bubbles, so bytes keep flowing while a result waits
// asynchronous active-low reset clears parser state and all pipe valids
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sentence_ok_o,
  output logic               command_seen_o,
  output logic [6:0]         utc_hours_o,
  output logic [6:0]         utc_minutes_o,
  output logic [6:0]         utc_seconds_o,
  output logic signed [27:0] latitude_udeg_o,
  output logic signed [28:0] longitude_udeg_o,
  output logic signed [20:0] altitude_dm_o
);

  localparam int         FW          = $clog2(10 ** FRAC_DIGITS);
  localparam int         SCALE_MICRO = 10 ** (6 - FRAC_DIGITS);
  localparam logic [2:0] FD_CNT      = 3'(FRAC_DIGITS);

  // parser state
  logic          in_sent_q, in_sent_d;
  logic [2:0]    hdr_pos_q, hdr_pos_d;
  logic [1:0]    hdr_match_q, hdr_match_d;
  logic [7:0]    xor_q, xor_d;
  logic          star_q, star_d;
  logic [1:0]    hex_q, hex_d;
  logic [7:0]    rxcs_q, rxcs_d;
  logic [3:0]    comma_q, comma_d;
  logic [19:0]   utc_q, utc_d;
  logic [13:0]   latw_q, latw_d;
  logic [FW-1:0] latf_q, latf_d;
  logic [16:0]   lonw_q, lonw_d;
  logic [FW-1:0] lonf_q, lonf_d;
  logic [20:0]   alt_q, alt_d;
  logic          point_q, point_d;
  logic          stop_q, stop_d;
  logic          started_q, started_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          hlat_q, hlat_d;
  logic          hlon_q, hlon_d;
  logic          halt_q, halt_d;
  logic          hutc_q, hutc_d;

  // pipe handshake
  logic rdy_out, rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_fire, s1_load;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;

  // stage 1: snapshot
  logic          s1_ok_q, s1_cmd_q, s1_latn_q, s1_lonn_q, s1_altn_q;
  logic [19:0]   s1_utc_q;
  logic [13:0]   s1_latw_q;
  logic [FW-1:0] s1_latf_q;
  logic [16:0]   s1_lonw_q;
  logic [FW-1:0] s1_lonf_q;
  logic [20:0]   s1_alt_q;
  // stage 2: quotients by 100
  logic          s2_ok_q, s2_cmd_q, s2_latn_q, s2_lonn_q, s2_altn_q;
  logic [19:0]   s2_utc_q;
  logic [13:0]   s2_q1_q;
  logic [13:0]   s2_latw_q;
  logic [6:0]    s2_latdeg_q;
  logic [FW-1:0] s2_latf_q;
  logic [16:0]   s2_lonw_q;
  logic [9:0]    s2_londeg_q;
  logic [FW-1:0] s2_lonf_q;
  logic [20:0]   s2_alt_q;
  // stage 3: remainders
  logic          s3_ok_q, s3_cmd_q, s3_latn_q, s3_lonn_q, s3_altn_q;
  logic [13:0]   s3_q1_q;
  logic [6:0]    s3_q2_q;
  logic [6:0]    s3_sec_q;
  logic [6:0]    s3_latdeg_q, s3_latmin_q;
  logic [FW-1:0] s3_latf_q;
  logic [9:0]    s3_londeg_q;
  logic [6:0]    s3_lonmin_q;
  logic [FW-1:0] s3_lonf_q;
  logic [20:0]   s3_alt_q;
  // stage 4: micro scaling
  logic          s4_ok_q, s4_cmd_q, s4_latn_q, s4_lonn_q, s4_altn_q;
  logic [6:0]    s4_hrs_q, s4_min_q, s4_sec_q;
  logic [26:0]   s4_latdeg_q, s4_latu_q;
  logic [29:0]   s4_londeg_q;
  logic [26:0]   s4_lonu_q;
  logic [20:0]   s4_alt_q;
  // stage 5: minutes to degrees
  logic          s5_ok_q, s5_cmd_q, s5_latn_q, s5_lonn_q, s5_altn_q;
  logic [6:0]    s5_hrs_q, s5_min_q, s5_sec_q;
  logic [26:0]   s5_latdeg_q;
  logic [20:0]   s5_latq_q;
  logic [29:0]   s5_londeg_q;
  logic [20:0]   s5_lonq_q;
  logic [20:0]   s5_alt_q;

  // byte decode
  logic                      is_digit;
  logic [3:0]                dig;
  logic                      num_field, hemi_field;
  logic [2:0]                cnt_inc;
  logic [23:0]               frac_prod;
  logic [FW-1:0]             frac_add;
  logic [23:0]               utc_mul;
  logic [19:0]               utc_next;
  logic [17:0]               latw_mul;
  logic [13:0]               latw_next;
  logic [20:0]               lonw_mul;
  logic [16:0]               lonw_next;
  logic [24:0]               altw_mul;
  logic [20:0]               altw_next;
  logic [21:0]               altf_sum;
  logic [20:0]               altf_next;
  nmea_gga_pkg::hex_t        hex_in;

  assign is_digit   = (rx_byte_i >= nmea_gga_pkg::CH_0) && (rx_byte_i <= nmea_gga_pkg::CH_9);
  assign dig        = rx_byte_i[3:0];
  assign num_field  = (comma_q == nmea_gga_pkg::FLD_UTC) || (comma_q == nmea_gga_pkg::FLD_LAT) ||
                      (comma_q == nmea_gga_pkg::FLD_LON) || (comma_q == nmea_gga_pkg::FLD_ALT);
  assign hemi_field = (comma_q == nmea_gga_pkg::FLD_LAT_HEMI) ||
                      (comma_q == nmea_gga_pkg::FLD_LON_HEMI);
  assign cnt_inc    = cnt_q + 3'd1;
  assign frac_prod  = 24'(dig) * 24'(nmea_gga_pkg::pow10(FD_CNT - cnt_inc));
  assign frac_add   = FW'(frac_prod);

  assign utc_mul   = 24'(utc_q) * 24'd10 + 24'(dig);
  assign utc_next  = (utc_mul > 24'(nmea_gga_pkg::UTC_CAP)) ? nmea_gga_pkg::UTC_CAP
                                                            : utc_mul[19:0];
  assign latw_mul  = 18'(latw_q) * 18'd10 + 18'(dig);
  assign latw_next = (latw_mul > 18'(nmea_gga_pkg::LAT_WHOLE_CAP)) ?
                     nmea_gga_pkg::LAT_WHOLE_CAP : latw_mul[13:0];
  assign lonw_mul  = 21'(lonw_q) * 21'd10 + 21'(dig);
  assign lonw_next = (lonw_mul > 21'(nmea_gga_pkg::LON_WHOLE_CAP)) ?
                     nmea_gga_pkg::LON_WHOLE_CAP : lonw_mul[16:0];
  assign altw_mul  = 25'(alt_q) * 25'd10 + 25'(dig) * 25'd10;
  assign altw_next = (altw_mul > 25'(nmea_gga_pkg::ALT_CAP)) ? nmea_gga_pkg::ALT_CAP
                                                             : altw_mul[20:0];
  assign altf_sum  = 22'(alt_q) + 22'(dig);
  assign altf_next = (altf_sum > 22'(nmea_gga_pkg::ALT_CAP)) ? nmea_gga_pkg::ALT_CAP
                                                             : altf_sum[20:0];
  assign hex_in    = nmea_gga_pkg::hex_digit(rx_byte_i);

  // bubble-collapsing ready chain
  assign rdy_out    = !out_v_q || out_ready_i;
  assign rdy5       = !s5_v_q || rdy_out;
  assign rdy4       = !s4_v_q || rdy5;
  assign rdy3       = !s3_v_q || rdy4;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && rdy1;

  always_comb begin
    in_sent_d   = in_sent_q;
    hdr_pos_d   = hdr_pos_q;
    hdr_match_d = hdr_match_q;
    xor_d       = xor_q;
    star_d      = star_q;
    hex_d       = hex_q;
    rxcs_d      = rxcs_q;
    comma_d     = comma_q;
    utc_d       = utc_q;
    latw_d      = latw_q;
    latf_d      = latf_q;
    lonw_d      = lonw_q;
    lonf_d      = lonf_q;
    alt_d       = alt_q;
    point_d     = point_q;
    stop_d      = stop_q;
    started_d   = started_q;
    cnt_d       = cnt_q;
    hlat_d      = hlat_q;
    hlon_d      = hlon_q;
    halt_d      = halt_q;
    hutc_d      = hutc_q;
    s1_load     = 1'b0;
    if (in_fire) begin
      if (rx_byte_i == nmea_gga_pkg::CH_DOLLAR) begin
        in_sent_d   = 1'b1;
        hdr_pos_d   = nmea_gga_pkg::HDR_FIRST;
        hdr_match_d = 2'b11;
        xor_d       = '0;
        star_d      = 1'b0;
        hex_d       = '0;
        rxcs_d      = '0;
        comma_d     = '0;
        utc_d       = '0;
        latw_d      = '0;
        latf_d      = '0;
        lonw_d      = '0;
        lonf_d      = '0;
        alt_d       = '0;
        point_d     = 1'b0;
        stop_d      = 1'b0;
        started_d   = 1'b0;
        cnt_d       = '0;
        hlat_d      = 1'b0;
        hlon_d      = 1'b0;
        halt_d      = 1'b0;
        hutc_d      = 1'b0;
      end else if (in_sent_q) begin
        if (rx_byte_i == nmea_gga_pkg::CH_CR) begin
          in_sent_d = 1'b0;
          s1_load   = 1'b1;
        end else begin
          if (hdr_pos_q >= nmea_gga_pkg::HDR_FIRST && hdr_pos_q < nmea_gga_pkg::HDR_END) begin
            if (rx_byte_i != nmea_gga_pkg::gga_char(hdr_pos_q - 3'd1)) begin
              hdr_match_d[0] = 1'b0;
            end
            if (rx_byte_i != nmea_gga_pkg::cmd_char(hdr_pos_q - 3'd1)) begin
              hdr_match_d[1] = 1'b0;
            end
            hdr_pos_d = hdr_pos_q + 3'd1;
          end
          if (!star_q) begin
            if (rx_byte_i == nmea_gga_pkg::CH_STAR) begin
              star_d = 1'b1;
              hex_d  = '0;
            end else begin
              xor_d = xor_q ^ rx_byte_i;
              if (rx_byte_i == nmea_gga_pkg::CH_COMMA) begin
                if (comma_q != nmea_gga_pkg::COMMA_MAX) begin
                  comma_d = comma_q + 4'd1;
                end
                point_d   = 1'b0;
                stop_d    = 1'b0;
                started_d = 1'b0;
                cnt_d     = '0;
              end else if (num_field && !stop_q) begin
                if (!started_q && (rx_byte_i == nmea_gga_pkg::CH_PLUS ||
                                   rx_byte_i == nmea_gga_pkg::CH_MINUS)) begin
                  started_d = 1'b1;
                  if (rx_byte_i == nmea_gga_pkg::CH_MINUS) begin
                    priority if (comma_q == nmea_gga_pkg::FLD_UTC) begin
                      hutc_d = 1'b1;
                    end else if (comma_q == nmea_gga_pkg::FLD_LAT) begin
                      hlat_d = !hlat_q;
                    end else if (comma_q == nmea_gga_pkg::FLD_LON) begin
                      hlon_d = !hlon_q;
                    end else begin
                      halt_d = 1'b1;
                    end
                  end
                end else begin
                  started_d = 1'b1;
                  if (is_digit) begin
                    if (!point_q) begin
                      priority if (comma_q == nmea_gga_pkg::FLD_UTC) begin
                        utc_d = utc_next;
                      end else if (comma_q == nmea_gga_pkg::FLD_LAT) begin
                        latw_d = latw_next;
                      end else if (comma_q == nmea_gga_pkg::FLD_LON) begin
                        lonw_d = lonw_next;
                      end else begin
                        alt_d = altw_next;
                      end
                    end else if (cnt_q < FD_CNT) begin
                      cnt_d = cnt_inc;
                      priority if (comma_q == nmea_gga_pkg::FLD_LAT) begin
                        latf_d = latf_q + frac_add;
                      end else if (comma_q == nmea_gga_pkg::FLD_LON) begin
                        lonf_d = lonf_q + frac_add;
                      end else if (comma_q == nmea_gga_pkg::FLD_ALT && cnt_q == 3'd0) begin
                        alt_d = altf_next;
                      end
                    end
                  end else if (rx_byte_i == nmea_gga_pkg::CH_DOT && !point_q) begin
                    point_d = 1'b1;
                  end else begin
                    stop_d = 1'b1;
                  end
                end
              end else if (hemi_field && !started_q) begin
                started_d = 1'b1;
                if (comma_q == nmea_gga_pkg::FLD_LAT_HEMI && rx_byte_i == nmea_gga_pkg::CH_S) begin
                  hlat_d = !hlat_q;
                end
                if (comma_q == nmea_gga_pkg::FLD_LON_HEMI && rx_byte_i == nmea_gga_pkg::CH_W) begin
                  hlon_d = !hlon_q;
                end
              end
            end
          end else if (hex_q < nmea_gga_pkg::HEX_DONE) begin
            if (!hex_in.ok) begin
              hex_d = nmea_gga_pkg::HEX_DONE;
            end else begin
              rxcs_d = {rxcs_q[3:0], hex_in.val};
              hex_d  = hex_q + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q   <= 1'b0;
      hdr_pos_q   <= '0;
      hdr_match_q <= 2'b11;
      xor_q       <= '0;
      star_q      <= 1'b0;
      hex_q       <= '0;
      rxcs_q      <= '0;
      comma_q     <= '0;
      utc_q       <= '0;
      latw_q      <= '0;
      latf_q      <= '0;
      lonw_q      <= '0;
      lonf_q      <= '0;
      alt_q       <= '0;
      point_q     <= 1'b0;
      stop_q      <= 1'b0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      hlat_q      <= 1'b0;
      hlon_q      <= 1'b0;
      halt_q      <= 1'b0;
      hutc_q      <= 1'b0;
    end else begin
      in_sent_q   <= in_sent_d;
      hdr_pos_q   <= hdr_pos_d;
      hdr_match_q <= hdr_match_d;
      xor_q       <= xor_d;
      star_q      <= star_d;
      hex_q       <= hex_d;
      rxcs_q      <= rxcs_d;
      comma_q     <= comma_d;
      utc_q       <= utc_d;
      latw_q      <= latw_d;
      latf_q      <= latf_d;
      lonw_q      <= lonw_d;
      lonf_q      <= lonf_d;
      alt_q       <= alt_d;
      point_q     <= point_d;
      stop_q      <= stop_d;
      started_q   <= started_d;
      cnt_q       <= cnt_d;
      hlat_q      <= hlat_d;
      hlon_q      <= hlon_d;
      halt_q      <= halt_d;
      hutc_q      <= hutc_d;
    end
  end

  // pipe valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= s1_load;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy3) begin
        s3_v_q <= s2_v_q;
      end
      if (rdy4) begin
        s4_v_q <= s3_v_q;
      end
      if (rdy5) begin
        s5_v_q <= s4_v_q;
      end
      if (rdy_out) begin
        out_v_q <= s5_v_q;
      end
    end
  end

  // stage 1 snapshot at end of sentence
  always_ff @(posedge clk_i) begin
    if (rdy1 && s1_load) begin
      s1_ok_q   <= (hdr_pos_q >= nmea_gga_pkg::HDR_END) && hdr_match_q[0] && star_q &&
                   (rxcs_q == xor_q);
      s1_cmd_q  <= (hdr_pos_q >= nmea_gga_pkg::HDR_END) && hdr_match_q[1];
      s1_utc_q  <= hutc_q ? '0 : utc_q;
      s1_latw_q <= latw_q;
      s1_latf_q <= latf_q;
      s1_lonw_q <= lonw_q;
      s1_lonf_q <= lonf_q;
      s1_latn_q <= hlat_q;
      s1_lonn_q <= hlon_q;
      s1_altn_q <= halt_q;
      s1_alt_q  <= alt_q;
    end
  end

  // stage 2
  logic [40:0] utc_div_p;
  logic [28:0] lat_div_p;
  logic [34:0] lon_div_p;

  assign utc_div_p = 41'(s1_utc_q) * 41'(nmea_gga_pkg::DIV100_M20);
  assign lat_div_p = 29'(s1_latw_q) * 29'(nmea_gga_pkg::DIV100_M14);
  assign lon_div_p = 35'(s1_lonw_q) * 35'(nmea_gga_pkg::DIV100_M17);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_ok_q     <= s1_ok_q;
      s2_cmd_q    <= s1_cmd_q;
      s2_latn_q   <= s1_latn_q;
      s2_lonn_q   <= s1_lonn_q;
      s2_altn_q   <= s1_altn_q;
      s2_alt_q    <= s1_alt_q;
      s2_utc_q    <= s1_utc_q;
      s2_q1_q     <= 14'(utc_div_p >> nmea_gga_pkg::DIV100_S20);
      s2_latw_q   <= s1_latw_q;
      s2_latdeg_q <= 7'(lat_div_p >> nmea_gga_pkg::DIV100_S14);
      s2_latf_q   <= s1_latf_q;
      s2_lonw_q   <= s1_lonw_q;
      s2_londeg_q <= 10'(lon_div_p >> nmea_gga_pkg::DIV100_S17);
      s2_lonf_q   <= s1_lonf_q;
    end
  end

  // stage 3
  logic [28:0] q1_div_p;
  logic [19:0] utc_sec_w;
  logic [13:0] lat_min_w;
  logic [16:0] lon_min_w;

  assign q1_div_p  = 29'(s2_q1_q) * 29'(nmea_gga_pkg::DIV100_M14);
  assign utc_sec_w = s2_utc_q - 20'(s2_q1_q) * 20'd100;
  assign lat_min_w = s2_latw_q - 14'(s2_latdeg_q) * 14'd100;
  assign lon_min_w = s2_lonw_q - 17'(s2_londeg_q) * 17'd100;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_ok_q     <= s2_ok_q;
      s3_cmd_q    <= s2_cmd_q;
      s3_latn_q   <= s2_latn_q;
      s3_lonn_q   <= s2_lonn_q;
      s3_altn_q   <= s2_altn_q;
      s3_alt_q    <= s2_alt_q;
      s3_q1_q     <= s2_q1_q;
      s3_q2_q     <= 7'(q1_div_p >> nmea_gga_pkg::DIV100_S14);
      s3_sec_q    <= utc_sec_w[6:0];
      s3_latdeg_q <= s2_latdeg_q;
      s3_latmin_q <= lat_min_w[6:0];
      s3_latf_q   <= s2_latf_q;
      s3_londeg_q <= s2_londeg_q;
      s3_lonmin_q <= lon_min_w[6:0];
      s3_lonf_q   <= s2_lonf_q;
    end
  end

  // stage 4
  logic [13:0] utc_min_w;

  assign utc_min_w = s3_q1_q - 14'(s3_q2_q) * 14'd100;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_ok_q     <= s3_ok_q;
      s4_cmd_q    <= s3_cmd_q;
      s4_latn_q   <= s3_latn_q;
      s4_lonn_q   <= s3_lonn_q;
      s4_altn_q   <= s3_altn_q;
      s4_alt_q    <= s3_alt_q;
      s4_hrs_q    <= s3_q2_q;
      s4_min_q    <= utc_min_w[6:0];
      s4_sec_q    <= s3_sec_q;
      s4_latdeg_q <= 27'(s3_latdeg_q) * 27'd1000000;
      s4_latu_q   <= 27'(s3_latmin_q) * 27'd1000000 + 27'(s3_latf_q) * 27'(SCALE_MICRO);
      s4_londeg_q <= 30'(s3_londeg_q) * 30'd1000000;
      s4_lonu_q   <= 27'(s3_lonmin_q) * 27'd1000000 + 27'(s3_lonf_q) * 27'(SCALE_MICRO);
    end
  end

  // stage 5: divide micro-minutes by 60 as a shift by 2 then divide by 15
  logic [50:0] lat_q_p;
  logic [50:0] lon_q_p;

  assign lat_q_p = 51'(s4_latu_q[26:2]) * 51'(nmea_gga_pkg::DIV15_M25);
  assign lon_q_p = 51'(s4_lonu_q[26:2]) * 51'(nmea_gga_pkg::DIV15_M25);

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      s5_ok_q     <= s4_ok_q;
      s5_cmd_q    <= s4_cmd_q;
      s5_latn_q   <= s4_latn_q;
      s5_lonn_q   <= s4_lonn_q;
      s5_altn_q   <= s4_altn_q;
      s5_alt_q    <= s4_alt_q;
      s5_hrs_q    <= s4_hrs_q;
      s5_min_q    <= s4_min_q;
      s5_sec_q    <= s4_sec_q;
      s5_latdeg_q <= s4_latdeg_q;
      s5_latq_q   <= 21'(lat_q_p >> nmea_gga_pkg::DIV15_S25);
      s5_londeg_q <= s4_londeg_q;
      s5_lonq_q   <= 21'(lon_q_p >> nmea_gga_pkg::DIV15_S25);
    end
  end

  // output register: saturate, sign, zero when not ok
  logic [26:0] lat_sum, lat_mag;
  logic [29:0] lon_sum, lon_mag;
  logic [27:0] lat_res;
  logic [28:0] lon_res;
  logic [20:0] alt_res;

  assign lat_sum = s5_latdeg_q + 27'(s5_latq_q);
  assign lon_sum = s5_londeg_q + 30'(s5_lonq_q);
  assign lat_mag = (lat_sum > nmea_gga_pkg::LAT_LIMIT) ? nmea_gga_pkg::LAT_LIMIT : lat_sum;
  assign lon_mag = (lon_sum > nmea_gga_pkg::LON_LIMIT) ? nmea_gga_pkg::LON_LIMIT : lon_sum;
  assign lat_res = s5_latn_q ? (28'd0 - 28'(lat_mag)) : 28'(lat_mag);
  assign lon_res = s5_lonn_q ? (29'd0 - 29'(lon_mag)) : 29'(lon_mag);
  assign alt_res = s5_altn_q ? (21'd0 - s5_alt_q) : s5_alt_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      sentence_ok_o    <= s5_ok_q;
      command_seen_o   <= s5_cmd_q;
      utc_hours_o      <= s5_ok_q ? s5_hrs_q : '0;
      utc_minutes_o    <= s5_ok_q ? s5_min_q : '0;
      utc_seconds_o    <= s5_ok_q ? s5_sec_q : '0;
      latitude_udeg_o  <= s5_ok_q ? signed'(lat_res) : '0;
      longitude_udeg_o <= s5_ok_q ? signed'(lon_res) : '0;
      altitude_dm_o    <= s5_ok_q ? signed'(alt_res) : '0;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
